@@ design/sii_pkg.sv @@
// shared types and opcodes for the spatial inertia inverse block
// no dependencies
`timescale 1ns / 1ps
package sii_pkg;
  // shared unit operations
  typedef enum logic [2:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_DIV
  } sii_op_t;
endpackage

@@ design/spatial_inertia_inverse.sv @@
// top level of the 6x6 spatial inertia inverse: load, sequenced compute, emit
// depends on sii_pkg
`timescale 1ns / 1ps
// usage
// the input channel takes one matrix element per request when start is high and
// busy is low: index, value and a last mark. elements may come one a cycle.
// the request that carries the last mark starts the inversion; busy stays high
// from then until the 36 result elements have been sent.
// the inversion runs a microcode sequencer over one shared unit that does a
// multiply, an add, a subtract or a bit-serial divide. a multiply, add or
// subtract step runs through two reads, execute, write and next; a divide
// step adds a bit-serial loop between execute and write.
// the program has 454 steps: 436 short steps (204 of them multiplies) and
// eighteen divides.
// results then appear in index order, each read from memory before it is sent
// and marked by out_valid for a single cycle; the receiver cannot stall them.
// a singular block ends the sequence early, clears the inverse and gives 36
// zero values with out_singular high.
// reset clears the sequencer and the singular flag; the stored matrix is
// undefined until written.
module spatial_inertia_inverse
  import sii_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [5:0]        in_element_index,
  input  logic signed [31:0] in_element_value,
  input  logic              in_last_element,
  output logic              out_valid,
  output logic [5:0]        out_result_index,
  output logic signed [31:0] out_result_value,
  output logic              out_result_last,
  output logic              out_singular
);
  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int NW = W + FRAC_BITS + 1;  // divide numerator width
  localparam int CW = $clog2(NW + 1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // one memory holds every value: matrix 0..35, scratch 36..194
  // layout: in 0..35, binv 36, m 45, n 54, ob 63, oa 72, oc 81, inv 99..134
  localparam int AW = 8;
  localparam logic [AW-1:0] BI = 8'd36, BM = 8'd45, BN = 8'd54, BO = 8'd63,
                            BA = 8'd72, BC = 8'd81, BV = 8'd99,
                            BAA = 8'd144, BBB = 8'd153, BCC = 8'd162, BDD = 8'd171,
                            BZ = 8'd180, BONE = 8'd181, BCOF = 8'd182, BDET = 8'd191,
                            BP = 8'd192;

  logic signed [W-1:0] mem [0:255];

  typedef enum logic [3:0] {
    S_LOAD, S_PREP, S_FETCH_A, S_FETCH_B, S_EXEC, S_DIV, S_WRITE, S_NEXT,
    S_ZERO, S_OUT_RD, S_OUT
  } state_t;

  // microinstruction produced by the step generator
  typedef struct packed {
    sii_op_t       op;
    logic [AW-1:0] a;
    logic [AW-1:0] b;
    logic [AW-1:0] d;
    logic          chk;   // destination is a determinant to test
    logic          stop;  // end of program
  } uop_t;

  state_t state_r;
  logic [11:0] pc_r;
  uop_t u;
  logic signed [W-1:0] ra_r, rb_r, res_r;
  logic sing_r;
  logic [5:0] oidx_r;
  logic [AW-1:0] raddr;
  logic signed [W-1:0] rdata_r;

  // divide datapath
  logic [NW-1:0] dn_r;
  logic [W:0]    dd_r;
  logic [NW:0]   rem_r;
  logic [NW-1:0] q_r;
  logic [CW-1:0] dcnt_r;
  logic          dneg_r;

  // saturate a wide signed value
  function automatic logic signed [W-1:0] sat(input logic signed [PW+1:0] v);
    if (v > $signed({{(PW+2-W){1'b0}}, VMAX})) sat = VMAX;
    else if (v < $signed({{(PW+2-W){1'b1}}, VMIN})) sat = VMIN;
    else sat = v[W-1:0];
  endfunction

  // rounded, saturated product on magnitudes
  function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic neg;
    logic [W-1:0] x, y;
    logic [PW:0] p;
    logic [PW:0] s;
    neg = a[W-1] ^ b[W-1];
    x = a[W-1] ? W'(-a) : W'(a);
    y = b[W-1] ? W'(-b) : W'(b);
    p = (PW+1)'(x) * (PW+1)'(y);
    s = (p + ((PW+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    qmul = sat(neg ? -$signed({1'b0, s}) : $signed({1'b0, s}));
  endfunction

  // step counters split by reciprocal multiply, exact over the ranges used
  function automatic logic [3:0] div3(input logic [11:0] v);  // v below 27
    return 4'((v * 12'd11) >> 5);
  endfunction

  function automatic logic [3:0] div5(input logic [11:0] v);  // v below 45
    return 4'((v * 12'd13) >> 6);
  endfunction

  function automatic logic [3:0] div6(input logic [11:0] v);  // v below 36
    return 4'((v * 12'd43) >> 8);
  endfunction

  function automatic logic [3:0] div9(input logic [11:0] v);  // v below 36
    return 4'((v * 12'd57) >> 9);
  endfunction

  // 3x3 product, five steps per element: three products, two adds
  function automatic uop_t mm_step(input logic [11:0] g, input logic [AW-1:0] x,
                                   input logic [AW-1:0] y, input logic [AW-1:0] z);
    uop_t o;
    logic [3:0] e, r, c, s;
    o = '{op: OP_ADD, a: BZ, b: BZ, d: BZ, chk: 1'b0, stop: 1'b0};
    e = div5(g); s = 4'(g - 12'(e) * 12'd5); r = div3(12'(e)); c = e - r * 4'd3;
    if (s < 3) begin
      o.op = OP_MUL; o.a = AW'(x + r * 3 + s); o.b = AW'(y + s * 3 + c);
      o.d = AW'(BP + s);
    end else if (s == 3) begin
      o.a = BP; o.b = AW'(BP + 1); o.d = BP;
    end else begin
      o.a = BP; o.b = AW'(BP + 2); o.d = AW'(z + e);
    end
    return o;
  endfunction

  // 3x3 inverse: 27 cofactor steps, 5 determinant steps, 9 divides
  function automatic uop_t inv_step(input logic [11:0] g, input logic [AW-1:0] m,
                                    input logic [AW-1:0] z);
    uop_t o;
    logic [3:0] e, s, r, c, r1, r2, c1, c2;
    o = '{op: OP_ADD, a: BZ, b: BZ, d: BZ, chk: 1'b0, stop: 1'b0};
    if (g < 27) begin
      e = div3(g); s = 4'(g - 12'(e) * 12'd3); r = div3(12'(e)); c = e - r * 4'd3;
      r1 = (r == 4'd2) ? 4'd0 : r + 4'd1; r2 = (r == 4'd0) ? 4'd2 : r - 4'd1;
      c1 = (c == 4'd2) ? 4'd0 : c + 4'd1; c2 = (c == 4'd0) ? 4'd2 : c - 4'd1;
      if (s == 0) begin
        o.op = OP_MUL; o.a = AW'(m + r1 * 3 + c1); o.b = AW'(m + r2 * 3 + c2); o.d = BP;
      end else if (s == 1) begin
        o.op = OP_MUL; o.a = AW'(m + r1 * 3 + c2); o.b = AW'(m + r2 * 3 + c1);
        o.d = AW'(BP + 1);
      end else begin
        o.op = OP_SUB; o.a = BP; o.b = AW'(BP + 1); o.d = AW'(BCOF + e);
      end
    end else if (g < 30) begin
      o.op = OP_MUL; o.a = AW'(m + g - 27); o.b = AW'(BCOF + g - 27);
      o.d = AW'(BP + g - 27);
    end else if (g == 30) begin
      o.a = BP; o.b = AW'(BP + 1); o.d = BP;
    end else if (g == 31) begin
      o.a = BP; o.b = AW'(BP + 2); o.d = BDET; o.chk = 1'b1;
    end else begin
      e = 4'(g - 12'd32); r = div3(12'(e)); c = e - r * 4'd3;
      o.op = OP_DIV; o.a = AW'(BCOF + c * 3 + r); o.b = BDET; o.d = AW'(z + e);
    end
    return o;
  endfunction

  // step generator for the whole program; its matrix product steps form z[r][c] over three k in scratch BP..BP+2
  function automatic uop_t gen(input logic [11:0] pc);
    uop_t o;
    logic [11:0] g;
    logic [3:0] blk;
    logic [3:0] e, r, c;
    logic [AW-1:0] x, z;
    o = '{op: OP_ADD, a: BZ, b: BZ, d: BZ, chk: 1'b0, stop: 1'b0};
    blk = '0; e = '0; g = '0; x = '0; z = '0;
    // phases of fixed length:
    // 0 copy blocks (36 adds), 1 inv B (9*3 cof + 5 det + 9 div), ...
    if (pc < 12'd36) begin
      // copy input blocks to aligned scratch: value + 0
      blk = div9(pc); e = 4'(pc - 12'(blk) * 12'd9); r = div3(12'(e)); c = e - r * 4'd3;
      o.a = AW'((blk[1] ? 18 : 0) + (blk[0] ? 3 : 0) + r * 6 + c);
      o.d = AW'(BAA + blk * 9 + e);
    end else if (pc < 12'd36 + 41) begin
      o = inv_step(pc - 12'd36, BBB, BI);
    end else if (pc < 12'd77 + 18) begin
      // negate binv; the last nine steps are spare zero adds
      g = pc - 12'd77;
      if (g < 9) begin o.op = OP_SUB; o.a = BZ; o.b = AW'(BI + g); o.d = AW'(BI + g); end
    end else if (pc < 12'd95 + 45) begin
      o = mm_step(pc - 12'd95, BDD, BI, BM);
    end else if (pc < 12'd140 + 45) begin
      o = mm_step(pc - 12'd140, BM, BAA, BN);
    end else if (pc < 12'd185 + 9) begin
      g = pc - 12'd185;
      o.a = AW'(BN + g); o.b = AW'(BCC + g); o.d = AW'(BN + g);
    end else if (pc < 12'd194 + 41) begin
      o = inv_step(pc - 12'd194, BN, BO);
    end else if (pc < 12'd235 + 45) begin
      o = mm_step(pc - 12'd235, BO, BDD, BM);
    end else if (pc < 12'd280 + 45) begin
      o = mm_step(pc - 12'd280, BM, BI, BA);
    end else if (pc < 12'd325 + 45) begin
      o = mm_step(pc - 12'd325, BAA, BA, BM);
    end else if (pc < 12'd370 + 3) begin
      g = pc - 12'd370;
      o.op = OP_SUB; o.a = AW'(BM + g * 4); o.b = BONE; o.d = AW'(BM + g * 4);
    end else if (pc < 12'd373 + 45) begin
      o = mm_step(pc - 12'd373, BI, BM, BC);
    end else if (pc < 12'd418 + 36) begin
      // place blocks into the inverse: A, B, C, transpose of A
      g = pc - 12'd418; r = div6(g); c = 4'(g - 12'(r) * 12'd6);
      z = AW'(BV + g);
      if (r < 3 && c < 3) x = AW'(BA + r * 3 + c);
      else if (r < 3) x = AW'(BO + r * 3 + c - 3);
      else if (c < 3) x = AW'(BC + (r - 3) * 3 + c);
      else x = AW'(BA + (c - 3) * 3 + r - 3);
      o.a = x; o.d = z;
    end else begin
      o.stop = 1'b1;
    end
    return o;
  endfunction

  assign u = gen(pc_r);

  always_comb begin
    case (state_r)
      S_FETCH_A: raddr = u.a;
      S_OUT_RD, S_OUT: raddr = AW'(BV + oidx_r);
      default: raddr = u.b;
    endcase
  end

  logic signed [PW+1:0] ext_a, ext_b;
  assign ext_a = (PW+2)'(ra_r);
  assign ext_b = (PW+2)'(rdata_r);

  logic [W:0] dsub;
  logic [NW:0] rem_sh;
  assign rem_sh = {rem_r[NW-1:0], dn_r[NW-1]};
  assign dsub = dd_r;

  logic signed [W-1:0] out_val;
  always_comb begin
    if (W > 32) begin
      if (rdata_r > $signed(W'(32'sh7fffffff))) out_val = W'(32'sh7fffffff);
      else if (rdata_r < $signed(W'(-33'sh80000000))) out_val = W'(-33'sh80000000);
      else out_val = rdata_r;
    end else begin
      out_val = rdata_r;
    end
  end

  logic [NW-1:0] qrnd;
  logic [W-1:0] amag, bmag;
  logic signed [PW+1:0] qs;
  assign amag = ra_r[W-1] ? W'(-ra_r) : W'(ra_r);
  assign bmag = rdata_r[W-1] ? W'(-rdata_r) : W'(rdata_r);
  assign qrnd = q_r;
  assign qs = dneg_r ? -$signed((PW+2)'(qrnd)) : $signed((PW+2)'(qrnd));

  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic signed [W-1:0] wr_data;

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_comb begin
    wr_en = 1'b0; wr_addr = u.d; wr_data = res_r;
    case (state_r)
      S_LOAD: begin
        wr_en = start && in_element_index < 6'd36;
        wr_addr = AW'(in_element_index);
        wr_data = sat((PW+2)'(in_element_value));
      end
      S_PREP: begin
        wr_en = 1'b1; wr_addr = pc_r[0] ? BONE : BZ;
        wr_data = pc_r[0] ? sat((PW+2)'(1) <<< FRAC_BITS) : '0;
      end
      S_WRITE: wr_en = 1'b1;
      S_ZERO: begin wr_en = 1'b1; wr_addr = AW'(BV + pc_r[5:0]); wr_data = '0; end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      pc_r <= '0;
      sing_r <= 1'b0;
      oidx_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == S_OUT) && pc_r[0];
      case (state_r)
        S_LOAD: if (start && in_last_element) begin
          state_r <= S_PREP; pc_r <= '0; sing_r <= 1'b0;
        end
        S_PREP: begin
          if (pc_r[0]) begin
            state_r <= S_FETCH_A; pc_r <= '0;
          end else begin
            pc_r <= pc_r + 12'd1;
          end
        end
        S_FETCH_A: state_r <= u.stop ? S_OUT_RD : S_FETCH_B;
        S_FETCH_B: begin ra_r <= rdata_r; state_r <= S_EXEC; end
        S_EXEC: begin
          case (u.op)
            OP_MUL: begin res_r <= qmul(ra_r, rdata_r); state_r <= S_WRITE; end
            OP_ADD: begin res_r <= sat(ext_a + ext_b); state_r <= S_WRITE; end
            OP_SUB: begin res_r <= sat(ext_a - ext_b); state_r <= S_WRITE; end
            OP_DIV: begin
              // numerator |a|<<F plus half divisor, then restoring division
              dneg_r <= ra_r[W-1] ^ rdata_r[W-1];
              dn_r <= (NW'(amag) << FRAC_BITS) + NW'(bmag >> 1);
              dd_r <= (W+1)'(bmag);
              rem_r <= '0; q_r <= '0; dcnt_r <= CW'(NW);
              state_r <= S_DIV;
            end
            default: state_r <= S_WRITE;
          endcase
        end
        S_DIV: begin
          if (dcnt_r == '0) begin
            res_r <= sat(qs); state_r <= S_WRITE;
          end else begin
            dn_r <= dn_r << 1;
            if (rem_sh >= (NW+1)'(dsub)) begin
              rem_r <= rem_sh - (NW+1)'(dsub); q_r <= {q_r[NW-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh; q_r <= {q_r[NW-2:0], 1'b0};
            end
            dcnt_r <= dcnt_r - CW'(1);
          end
        end
        S_WRITE: state_r <= S_NEXT;
        S_NEXT: begin
          if (u.chk && res_r == '0) begin
            sing_r <= 1'b1; pc_r <= '0; state_r <= S_ZERO;
          end else begin
            pc_r <= pc_r + 12'd1; state_r <= S_FETCH_A;
          end
        end
        S_ZERO: begin
          pc_r <= pc_r + 12'd1;
          if (pc_r == 12'd35) state_r <= S_OUT_RD;
        end
        S_OUT_RD: begin oidx_r <= '0; state_r <= S_OUT; end
        S_OUT: begin
          // memory read of oidx lands in the next cycle; pc_r[0] alternates a read cycle and a send cycle
          if (pc_r[0] == 1'b0) begin
            pc_r[0] <= 1'b1;
          end else begin
            pc_r[0] <= 1'b0;
            out_result_index <= oidx_r;
            out_result_value <= 32'(out_val);
            out_result_last <= oidx_r == 6'd35;
            out_singular <= sing_r;
            oidx_r <= oidx_r + 6'd1;
            if (oidx_r == 6'd35) state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign busy = state_r != S_LOAD;
endmodule

@@ tb/spatial_inertia_inverse_tb.sv @@
// testbench for spatial_inertia_inverse: element loads, partitioned inverse, 36 results
// predicts each inversion in saturating fixed point and checks every result element
// depends on sii_pkg and spatial_inertia_inverse
`timescale 1ns / 1ps
module spatial_inertia_inverse_tb;
  import sii_pkg::*;

  localparam int  FRAC  = 16;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint ONE  = 64'sd65536;
  localparam logic signed [31:0] ONE_Q = 32'sh00010000;

  typedef longint blk_t[9];
  typedef struct {
    logic [5:0]        idx;
    logic signed [31:0] val;
    logic              last;
    logic              sing;
  } inv_elem_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [5:0]        in_element_index = '0;
  logic signed [31:0] in_element_value = '0;
  logic              in_last_element = 1'b0;
  logic              out_valid;
  logic [5:0]        out_result_index;
  logic signed [31:0] out_result_value;
  logic              out_result_last;
  logic              out_singular;

  inv_elem_t pending_inverse[$];
  longint    loaded[36];
  int        mismatches = 0;
  bit        timed_out = 1'b0;

  spatial_inertia_inverse uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_element_index(in_element_index), .in_element_value(in_element_value),
    .in_last_element(in_last_element), .out_valid(out_valid),
    .out_result_index(out_result_index), .out_result_value(out_result_value),
    .out_result_last(out_result_last), .out_singular(out_singular)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------- fixed point predictor ----------------
  function automatic longint sat(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint from_mag(bit neg, logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? 128'd2147483648 : 128'd2147483647;
    if (m > lim) m = lim;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    longint p;
    logic [127:0] m;
    p = a * b;
    m = (p < 0) ? 128'(-p) : 128'(p);
    m = (m + (128'd1 << (FRAC - 1))) >> FRAC;
    return from_mag(p < 0, m);
  endfunction

  function automatic longint q_div(longint n, longint d);
    logic [127:0] un, ud, num;
    un = (n < 0) ? 128'(-n) : 128'(n);
    ud = (d < 0) ? 128'(-d) : 128'(d);
    num = (un << FRAC) + (ud >> 1);
    return from_mag((n < 0) != (d < 0), num / ud);
  endfunction

  function automatic blk_t blk_mul(blk_t x, blk_t y);
    blk_t t;
    longint s;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        s = q_mul(x[r*3], y[c]);
        for (int k = 1; k < 3; k++) s = sat(s + q_mul(x[r*3+k], y[k*3+c]));
        t[r*3+c] = s;
      end
    return t;
  endfunction

  // returns 1 when the determinant rounds to zero
  function automatic bit blk_inv(blk_t m, output blk_t z);
    blk_t cof;
    longint det;
    int r1, r2, c1, c2;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        r1 = (r + 1) % 3; r2 = (r + 2) % 3; c1 = (c + 1) % 3; c2 = (c + 2) % 3;
        cof[r*3+c] = sat(q_mul(m[r1*3+c1], m[r2*3+c2]) - q_mul(m[r1*3+c2], m[r2*3+c1]));
      end
    det = sat(sat(q_mul(m[0], cof[0]) + q_mul(m[1], cof[1])) + q_mul(m[2], cof[2]));
    z = '{default: 0};
    if (det == 0) return 1'b1;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) z[r*3+c] = q_div(cof[c*3+r], det);
    return 1'b0;
  endfunction

  function automatic blk_t take_blk(int r0, int c0);
    blk_t z;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) z[r*3+c] = loaded[(r0+r)*6 + c0 + c];
    return z;
  endfunction

  task automatic predict_inverse();
    blk_t a, b, cc, d, binv, m, n, oa, ob, oc;
    longint res[36];
    bit sing;
    inv_elem_t e;
    res = '{default: 0};
    a = take_blk(0, 0); b = take_blk(0, 3); cc = take_blk(3, 0); d = take_blk(3, 3);
    sing = blk_inv(b, binv);
    if (!sing) begin
      for (int i = 0; i < 9; i++) binv[i] = sat(-binv[i]);
      n = blk_mul(blk_mul(d, binv), a);
      for (int i = 0; i < 9; i++) n[i] = sat(n[i] + cc[i]);
      sing = blk_inv(n, ob);
      if (!sing) begin
        oa = blk_mul(blk_mul(ob, d), binv);
        m = blk_mul(a, oa);
        for (int i = 0; i < 3; i++) m[i*4] = sat(m[i*4] - ONE);
        oc = blk_mul(binv, m);
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++) begin
            res[r*6+c]       = oa[r*3+c];
            res[r*6+c+3]     = ob[r*3+c];
            res[(r+3)*6+c]   = oc[r*3+c];
            res[(r+3)*6+c+3] = oa[c*3+r];
          end
      end
    end
    for (int k = 0; k < 36; k++) begin
      e.idx = 6'(k); e.val = 32'(res[k]); e.last = (k == 35); e.sing = sing;
      pending_inverse.push_back(e);
    end
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    inv_elem_t e;
    if (rst_n && out_valid) begin
      if (pending_inverse.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result idx %0d val %h", out_result_index,
                                       out_result_value);
      end else begin
        e = pending_inverse.pop_front();
        if (out_result_index !== e.idx || out_result_value !== e.val ||
            out_result_last !== e.last || out_singular !== e.sing) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx %0d val %h last %b sing %b, got %0d %h %b %b",
                     e.idx, e.val, e.last, e.sing, out_result_index, out_result_value,
                     out_result_last, out_singular);
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_request(logic [5:0] idx, logic signed [31:0] val, logic last,
                              bit allow_gap = 1'b1);
    int g;
    g = allow_gap ? pick_gap() : 0;
    if (g > 0) begin
      @(negedge clk) start = 1'b0;
      repeat (g) @(posedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_element_index = idx;
    in_element_value = val;
    in_last_element = last;
    do @(posedge clk); while (busy);
    if (idx < 36) loaded[idx] = val;
    if (last) predict_inverse();
  endtask

  function automatic logic signed [31:0] rand_q();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $signed(32'($urandom_range(0, 2**19))) - 32'sd262144;
    if (p < 85) return $urandom;
    if (p < 90) return (p[0]) ? 32'sh7fffffff : 32'sh80000000;
    return '0;
  endfunction

  // full load; a bias on the diagonals of the B and C blocks keeps most matrices well conditioned
  task automatic load_matrix(bit structured);
    logic signed [31:0] v;
    for (int k = 0; k < 36; k++) begin
      if (structured) v = ((k % 7) == 0 || k == 3 || k == 10 || k == 17) ? ONE_Q : 32'sd0;
      else begin
        v = rand_q();
        if ($urandom_range(0, 3) != 0 && (k % 6) == (k / 6 + 3) % 6)
          v = 32'sd262144 + (v >>> 4);
      end
      send_request(6'(k), v, k == 35);
    end
  endtask

  task automatic test_simple_matrix();
    load_matrix(1'b1);
  endtask

  task automatic test_singular_b();
    for (int c = 3; c < 6; c++) send_request(6'(c), '0, 1'b0);
    send_request(6'd63, '0, 1'b1);
    for (int c = 3; c < 6; c++) send_request(6'(c), (c == 3) ? ONE_Q : 32'sd0, c == 5);
  endtask

  task automatic test_singular_schur();
    for (int k = 0; k < 36; k++)
      send_request(6'(k), (k == 3 || k == 10 || k == 17 || k == 21 || k == 28 || k == 35)
                   ? ONE_Q : 32'sd0, k == 35);
  endtask

  task automatic test_extremes();
    send_request(6'd0, 32'sh7fffffff, 1'b0);
    send_request(6'd14, 32'sh80000000, 1'b0);
    send_request(6'd35, 32'sh7fffffff, 1'b0);
    send_request(6'd42, 32'sh55555555, 1'b1);
    send_request(6'd21, 32'shffffffff, 1'b1);
  endtask

  // the directed tests send 84 requests; this brings the run to at least 230
  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 146) begin
      if ($urandom_range(0, 3) == 0) begin
        load_matrix(1'b0);
        sent += 36;
      end else begin
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
          send_request(($urandom_range(0, 9) == 0) ? 6'($urandom_range(36, 63))
                                                   : 6'($urandom_range(0, 35)),
                       rand_q(), i == n - 1);
        sent += n;
      end
    end
  endtask

  initial begin
    for (int k = 0; k < 36; k++) loaded[k] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    test_simple_matrix();
    test_singular_b();
    test_singular_schur();
    test_extremes();
    test_random();
    @(negedge clk) start = 1'b0;
    while (pending_inverse.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && !timed_out) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    timed_out = 1'b1;
    $display("FAIL");
    $finish;
  end
endmodule
